// ===== hdl/fcfsrq_pkg.sv =====
// ============================================================================
// fcfsrq_pkg
// Shared types and codes for the first-come-first-served ready queue.
// ============================================================================
package fcfsrq_pkg;

   // Process numbers as they appear on the ports.
   localparam int ID_W = 6;
   typedef logic [ID_W-1:0] id_type;

   // Default number of process slots.
   localparam int DEF_NUM_PROCS = 64;

   // Command codes.
   typedef logic [1:0] cmd_type;
   localparam cmd_type CMD_APPEND     = 2'd0;
   localparam cmd_type CMD_PUSH_FRONT = 2'd1;
   localparam cmd_type CMD_REMOVE     = 2'd2;
   localparam cmd_type CMD_PICK       = 2'd3;

   // Status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_DONE = 2'd0;
   localparam status_type ST_MISS = 2'd1;
   localparam status_type ST_DUP  = 2'd2;

endpackage

// ===== hdl/fcfs_ready_queue.sv =====
// Timing: append, insert at head, pick and a remove of an absent process give
// their result word in the cycle after acceptance. Removing a queued process
// reads its link in S_SUCC and, unless it is the head, walks links in S_WALK.
// Throughput: one request at a time; the next is taken once the result is
// registered. The walk reads one link per cycle through the link memory port.
// Reset: synchronous; the queue comes up empty, no queued marks, no clearing pass.
// ============================================================================
// fcfs_ready_queue
// Ready queue of process numbers kept as a singly linked list in a memory,
// with append, insert at head, remove by walking the list, and pick.
// ============================================================================
module fcfs_ready_queue
   import fcfsrq_pkg::*;
#(
   parameter int NUM_PROCS = DEF_NUM_PROCS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  cmd_type    req_command,
   input  id_type     req_proc_id,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output status_type rsp_status,
   output id_type     rsp_head_id,
   output logic       rsp_queue_empty
);

   // Only process numbers that fit on the port can ever be queued.
   localparam int DEPTH  = (NUM_PROCS < (1 << ID_W)) ? NUM_PROCS : (1 << ID_W);
   localparam int ADDR_W = $clog2(DEPTH);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SUCC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;

   logic [1:0]       state_ff, state_in;
   id_type           head_ff, head_in;
   id_type           tail_ff, tail_in;
   logic             empty_ff, empty_in;
   logic [DEPTH-1:0] queued_ff, queued_in;
   id_type           pid_ff, pid_in;
   id_type           succ_ff, succ_in;
   id_type           prev_ff, prev_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   id_type           rsp_head_ff;
   logic             rsp_empty_ff;

   logic              out_free;
   logic              req_accept;
   logic              id_ok;
   logic              is_marked;
   logic [ADDR_W-1:0] req_addr;
   logic              load;
   status_type        status;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   id_type            wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   id_type            rd_data;

   // Handshake on both channels.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != S_IDLE) || !out_free;
   assign req_accept = req_valid && !req_stall;

   // Decode of the requested process.
   assign id_ok     = int'(req_proc_id) < NUM_PROCS;
   assign req_addr  = ADDR_W'(req_proc_id);
   assign is_marked = id_ok && queued_ff[req_addr];

   // Command sequencer: inserts, picks and misses finish at once; removes of a queued process read links.
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      queued_in = queued_ff;
      pid_in    = pid_ff;
      succ_in   = succ_ff;
      prev_in   = prev_ff;
      load      = 1'b0;
      status    = ST_DONE;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = '0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_command) inside
                  CMD_APPEND, CMD_PUSH_FRONT: begin
                     load = 1'b1;
                     if (!id_ok) begin
                        status = ST_MISS;
                     end else if (is_marked) begin
                        status = ST_DUP;
                     end else begin
                        queued_in[req_addr] = 1'b1;
                        if (empty_ff) begin
                           head_in  = req_proc_id;
                           tail_in  = req_proc_id;
                           empty_in = 1'b0;
                        end else if (req_command == CMD_APPEND) begin
                           wr_en   = 1'b1;
                           wr_addr = ADDR_W'(tail_ff);
                           wr_data = req_proc_id;
                           tail_in = req_proc_id;
                        end else begin
                           wr_en   = 1'b1;
                           wr_addr = req_addr;
                           wr_data = head_ff;
                           head_in = req_proc_id;
                        end
                     end
                  end
                  CMD_REMOVE: begin
                     if (!is_marked || empty_ff) begin
                        load   = 1'b1;
                        status = ST_MISS;
                     end else begin
                        // Fetch the successor of the process first.
                        rd_en    = 1'b1;
                        rd_addr  = req_addr;
                        pid_in   = req_proc_id;
                        state_in = S_SUCC;
                     end
                  end
                  default: begin
                     load   = 1'b1;
                     status = empty_ff ? ST_MISS : ST_DONE;
                  end
               endcase
            end
         end
         S_SUCC: begin
            if (head_ff == pid_ff) begin
               // Removing the head: the successor becomes the head.
               if (out_free) begin
                  load = 1'b1;
                  queued_in[ADDR_W'(pid_ff)] = 1'b0;
                  if (tail_ff == pid_ff) begin
                     empty_in = 1'b1;
                  end else begin
                     head_in = rd_data;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               succ_in  = rd_data;
               prev_in  = head_ff;
               rd_en    = 1'b1;
               rd_addr  = ADDR_W'(head_ff);
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            // Word on rd_data is the link of prev_ff.
            if (prev_ff == tail_ff) begin
               if (out_free) begin
                  load     = 1'b1;
                  status   = ST_MISS;
                  state_in = S_IDLE;
               end
            end else if (rd_data == pid_ff) begin
               if (out_free) begin
                  load = 1'b1;
                  queued_in[ADDR_W'(pid_ff)] = 1'b0;
                  if (tail_ff == pid_ff) begin
                     tail_in = prev_ff;
                  end else begin
                     wr_en   = 1'b1;
                     wr_addr = ADDR_W'(prev_ff);
                     wr_data = succ_ff;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               prev_in = rd_data;
               rd_en   = 1'b1;
               rd_addr = ADDR_W'(rd_data);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         empty_ff     <= empty_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk registers and the result word.
   always_ff @(posedge clock) begin
      pid_ff  <= pid_in;
      succ_ff <= succ_in;
      prev_ff <= prev_in;
      if (load) begin
         rsp_status_ff <= status;
         rsp_head_ff   <= empty_in ? '0 : head_in;
         rsp_empty_ff  <= empty_in;
      end
   end

   fcfsrq_link_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_id     = rsp_head_ff;
   assign rsp_queue_empty = rsp_empty_ff;

endmodule

// ===== hdl/fcfsrq_link_ram.sv =====
// ============================================================================
// fcfsrq_link_ram
// Successor-link store of the ready queue: one write port and one read port,
// read data registered and held while no read is issued.
// ============================================================================
module fcfsrq_link_ram
   import fcfsrq_pkg::*;
#(
   parameter int DEPTH  = DEF_NUM_PROCS,
   parameter int ADDR_W = $clog2(DEF_NUM_PROCS)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  id_type            wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output id_type            rd_data
);

   id_type link_mem [DEPTH];
   id_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         link_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; the last word stays until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= link_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fcfsrq_checker.sv =====
// ============================================================================
// fcfsrq_checker
// Port-level checks of the ready queue, bound to the top level.
// ============================================================================
module fcfsrq_checker
   import fcfsrq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input cmd_type    req_command,
   input id_type     req_proc_id,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input status_type rsp_status,
   input id_type     rsp_head_id,
   input logic       rsp_queue_empty
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // An empty queue reports head zero.
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_queue_empty |-> rsp_head_id == '0)
      else $error("head reported on empty queue");

   // Status is one of the defined codes.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_MISS ||
                     rsp_status == ST_DUP))
      else $error("undefined status code");

   // A pick answers in the next cycle.
   a_pick_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_PICK |=> rsp_valid)
      else $error("pick result late");

   // A pick on a non-empty queue never reports a miss.
   a_pick_status: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_command == CMD_PICK
         |=> (rsp_status == ST_MISS) == rsp_queue_empty)
      else $error("pick status disagrees with empty flag");

endmodule

bind fcfs_ready_queue fcfsrq_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_command     (req_command),
   .req_proc_id     (req_proc_id),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_head_id     (rsp_head_id),
   .rsp_queue_empty (rsp_queue_empty)
);

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives append, insert at head, remove and pick words into the ready queue
// under random idling and receiver back-pressure. A linked-list copy of the
// queue predicts each reply word, and every reply is checked field by field.
// ============================================================================
module testbench;
   import fcfsrq_pkg::*;

   localparam int NUM_PROCS  = DEF_NUM_PROCS;
   localparam int IDLE_LIMIT = 3000;

   // One reply word as the block presents it.
   typedef struct packed {
      status_type status;
      id_type     head_id;
      logic       queue_empty;
   } reply_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   cmd_type    req_command = CMD_PICK;
   id_type     req_proc_id = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   status_type rsp_status;
   id_type     rsp_head_id;
   logic       rsp_queue_empty;

   // Our own copy of the ready queue, updated as each word is accepted.
   id_type succ [NUM_PROCS] = '{default: '0};
   logic   on_queue [NUM_PROCS] = '{default: 1'b0};
   id_type q_head = '0;
   id_type q_tail = '0;
   logic   q_empty = 1'b1;
   int     q_len = 0;

   // Replies owed by the block, oldest first.
   reply_word_type replies_due[$];

   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   int  hold_len = 0;
   bit  send_idle = 1'b1;
   bit  recv_idle = 1'b1;

   fcfs_ready_queue #(.NUM_PROCS(NUM_PROCS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_proc_id     (req_proc_id),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_head_id     (rsp_head_id),
      .rsp_queue_empty (rsp_queue_empty)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one command to the queue copy and returns the reply it earns.
   function automatic reply_word_type ready_queue_step(cmd_type cmd, id_type pid);
      reply_word_type reply;
      status_type     st;
      id_type         prev;
      bit             in_range;
      st = ST_DONE;
      in_range = int'(pid) < NUM_PROCS;
      case (cmd) inside
         CMD_APPEND, CMD_PUSH_FRONT: begin
            if (!in_range) begin
               st = ST_MISS;
            end else if (on_queue[pid]) begin
               st = ST_DUP;
            end else begin
               if (q_empty) begin
                  q_head = pid;
                  q_tail = pid;
                  succ[pid] = '0;
                  q_empty = 1'b0;
               end else if (cmd == CMD_APPEND) begin
                  succ[q_tail] = pid;
                  succ[pid] = '0;
                  q_tail = pid;
               end else begin
                  succ[pid] = q_head;
                  q_head = pid;
               end
               on_queue[pid] = 1'b1;
               q_len++;
            end
         end
         CMD_REMOVE: begin
            if (!in_range || !on_queue[pid] || q_empty) begin
               st = ST_MISS;
            end else if (q_head == pid) begin
               // Removing the head; the queue empties when it was also the tail.
               if (q_tail == pid) q_empty = 1'b1;
               else q_head = succ[pid];
               on_queue[pid] = 1'b0;
               q_len--;
            end else begin
               // Walk from the head to find the predecessor and unlink.
               st = ST_MISS;
               prev = q_head;
               for (int i = 0; i < NUM_PROCS && st == ST_MISS && prev != q_tail; i++) begin
                  if (succ[prev] == pid) begin
                     if (q_tail == pid) q_tail = prev;
                     else succ[prev] = succ[pid];
                     on_queue[pid] = 1'b0;
                     q_len--;
                     st = ST_DONE;
                  end else begin
                     prev = succ[prev];
                  end
               end
            end
         end
         default: st = q_empty ? ST_MISS : ST_DONE;
      endcase
      reply.status = st;
      reply.head_id = q_empty ? id_type'(0) : q_head;
      reply.queue_empty = q_empty;
      return reply;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99, 0);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Finds a random process number that is queued, or one that is not.
   function automatic id_type find_id(bit want_queued);
      int start;
      id_type pid;
      start = $urandom_range(NUM_PROCS - 1, 0);
      for (int k = 0; k < NUM_PROCS; k++) begin
         pid = id_type'((start + k) % NUM_PROCS);
         if (on_queue[pid] == want_queued) return pid;
      end
      return id_type'(start);
   endfunction

   task automatic report_error(string what);
      error_count++;
      $display("%0t: %s", $time, what);
   endtask

   // Offers one word, waits for it to be taken, then may idle for a random gap.
   task automatic send_word(cmd_type cmd, id_type pid);
      int gap;
      req_valid <= 1'b1;
      req_command <= cmd;
      req_proc_id <= pid;
      do @(posedge clock); while (req_stall);
      replies_due.push_back(ready_queue_step(cmd, pid));
      gap = send_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Receiver stall pattern; a requested hold-off is counted down here.
   always @(posedge clock) begin
      if (hold_len != 0) begin
         stall_left = hold_len;
         hold_len = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_left = recv_idle ? pick_gap() : 0;
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0) stall_left--;
      end
   end

   // Each accepted reply word is compared with the oldest one owed.
   always @(posedge clock) begin : check_reply
      reply_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (replies_due.size() == 0) begin
            report_error($sformatf("reply word with none owed: status %0d head %0d empty %0d",
                                   rsp_status, rsp_head_id, rsp_queue_empty));
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status)
               report_error($sformatf("status expected %0d, got %0d",
                                      want.status, rsp_status));
            if (rsp_head_id !== want.head_id)
               report_error($sformatf("head_id expected %0d, got %0d",
                                      want.head_id, rsp_head_id));
            if (rsp_queue_empty !== want.queue_empty)
               report_error($sformatf("queue_empty expected %0d, got %0d",
                                      want.queue_empty, rsp_queue_empty));
         end
      end
   end

   // Watchdog: too long without any word moving on either channel.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Every command, both duplicate kinds, absent removes and the empty queue.
   task automatic test_basic_commands();
      send_word(CMD_PICK, 6'd0);
      send_word(CMD_REMOVE, 6'd5);
      send_word(CMD_APPEND, 6'd0);
      send_word(CMD_APPEND, 6'd63);
      send_word(CMD_PUSH_FRONT, 6'd21);
      send_word(CMD_PUSH_FRONT, 6'd42);
      send_word(CMD_APPEND, 6'd63);
      send_word(CMD_PUSH_FRONT, 6'd0);
      send_word(CMD_PICK, 6'd63);
      send_word(CMD_REMOVE, 6'd63);
      send_word(CMD_REMOVE, 6'd21);
      send_word(CMD_REMOVE, 6'd42);
      send_word(CMD_REMOVE, 6'd42);
      send_word(CMD_REMOVE, 6'd0);
      send_word(CMD_PICK, 6'd42);
      send_word(CMD_PUSH_FRONT, 6'd7);
      send_word(CMD_APPEND, 6'd56);
      send_word(CMD_REMOVE, 6'd56);
      send_word(CMD_REMOVE, 6'd7);
   endtask

   // Mixed traffic steered toward a fill level that changes every 50 words.
   task automatic test_random_traffic(int count);
      int fill_goal;
      int r;
      cmd_type cmd;
      id_type pid;
      fill_goal = 0;
      for (int n = 0; n < count; n++) begin
         if (n % 50 == 0)
            fill_goal = ($urandom_range(4, 0) == 0) ? NUM_PROCS : $urandom_range(24, 0);
         r = $urandom_range(99, 0);
         if (r < 8) begin
            cmd = CMD_PICK;
            pid = id_type'($urandom);
         end else if (r < 14) begin
            // Noise: any command, any process, so duplicates and misses show up.
            cmd = cmd_type'($urandom_range(3, 0));
            pid = id_type'($urandom);
         end else if (q_len == 0 || (q_len < fill_goal && q_len < NUM_PROCS)) begin
            cmd = ($urandom_range(2, 0) == 0) ? CMD_PUSH_FRONT : CMD_APPEND;
            pid = find_id(1'b0);
         end else begin
            cmd = CMD_REMOVE;
            pid = find_id(1'b1);
         end
         send_word(cmd, pid);
      end
   endtask

   // Fill every slot, remove the tail (longest walk), then drain at random.
   task automatic test_full_queue();
      while (q_len < NUM_PROCS)
         send_word(($urandom_range(1, 0) == 0) ? CMD_APPEND : CMD_PUSH_FRONT, find_id(1'b0));
      send_word(CMD_APPEND, q_tail);
      send_word(CMD_PICK, 6'd0);
      send_word(CMD_REMOVE, q_tail);
      while (q_len > 0)
         send_word(CMD_REMOVE, find_id(1'b1));
      send_word(CMD_PICK, 6'd0);
   endtask

   // The receiver holds off while the sender keeps offering words.
   task automatic test_output_hold_off();
      send_idle = 1'b0;
      hold_len = 300;
      test_random_traffic(40);
      send_idle = 1'b1;
   endtask

   // Both sides run without idling.
   task automatic test_back_to_back();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_random_traffic(250);
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_commands();
      test_full_queue();
      test_output_hold_off();
      test_back_to_back();
      test_random_traffic(1300);
      test_full_queue();
      req_valid <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
